// File: hdl/pdo_transmit_trigger_scheduler_unit_defines.svh
// Assertion macros shared by the PDO trigger scheduler RTL.
// Needs i_clk and i_rst_n in the scope where a macro is used.
`ifndef PDO_TRANSMIT_TRIGGER_SCHEDULER_UNIT_DEFINES_SVH
`define PDO_TRANSMIT_TRIGGER_SCHEDULER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PDOTTS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define PDOTTS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/pdotts_pkg.sv
`timescale 1ns / 1ps
// Types, codes and the microcode ROM of the PDO trigger scheduler.
// No dependencies; used by the interfaces, the remainder unit, the sequencer, the top level and the bench.
package pdotts_pkg;

    typedef logic [1:0]  t_func;
    typedef logic [1:0]  t_pdo;
    typedef logic [7:0]  t_cnt8;
    typedef logic [31:0] t_time;
    typedef logic [2:0]  t_cfg_idx;
    typedef logic [63:0] t_cfg_data;
    typedef logic [3:0]  t_pc;

    // Event kinds
    localparam t_func FUNC_TICK = 2'd0;
    localparam t_func FUNC_SYNC = 2'd1;
    localparam t_func FUNC_RTR  = 2'd2;
    localparam t_func FUNC_APP  = 2'd3;

    // Configuration register indexes
    localparam t_cfg_idx CFG_NODE_ENABLE = 3'd0;
    localparam t_cfg_idx CFG_TX_TYPES    = 3'd1;
    localparam t_cfg_idx CFG_EVT_TIMERS  = 3'd2;
    localparam t_cfg_idx CFG_INH_TIMES   = 3'd3;
    localparam t_cfg_idx CFG_PDO_ENABLE  = 3'd4;
    localparam t_cfg_idx CFG_TMR_SUP     = 3'd5;
    localparam t_cfg_idx CFG_INH_SUP     = 3'd6;
    localparam t_cfg_idx CFG_SYNC_WIN    = 3'd7;

    // Transmission types
    localparam logic [7:0] TYPE_ACYCLIC   = 8'd0;
    localparam logic [7:0] TYPE_SYNC_MAX  = 8'd240;
    localparam logic [7:0] TYPE_RTR_SYNC  = 8'd252;
    localparam logic [7:0] TYPE_RTR_EVENT = 8'd253;
    localparam logic [7:0] TYPE_EVENT_A   = 8'd254;

    localparam t_time MS_TO_US        = 32'd1000;
    localparam t_time INHIBIT_UNIT_US = 32'd100;

    // Datapath operations of one step
    typedef enum logic [3:0] {
        OP_NOP,
        OP_LD_TMR,
        OP_LD_INH,
        OP_MOD_GO,
        OP_EV_TICK,
        OP_EV_SYNC,
        OP_EV_RTR,
        OP_EV_APP,
        OP_FLUSH
    } t_op;

    // Jump conditions
    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_MORE,
        C_BUSY,
        C_ABORT
    } t_cond;

    typedef struct packed {
        t_op   op;
        logic  inc;
        t_cond cond;
        t_pc   tgt;
    } t_uword;

    // Status from the datapath that the jumps test
    typedef struct packed {
        logic more;
        logic busy;
        logic abort;
    } t_flags;

    // Program addresses
    localparam t_pc ST_IDLE     = 4'd0;
    localparam t_pc ST_TK_LD    = 4'd1;
    localparam t_pc ST_TK_EV    = 4'd2;
    localparam t_pc ST_FLUSH    = 4'd3;
    localparam t_pc ST_SY_CHK   = 4'd4;
    localparam t_pc ST_SY_GO    = 4'd5;
    localparam t_pc ST_SY_WAIT  = 4'd6;
    localparam t_pc ST_SY_EV    = 4'd7;
    localparam t_pc ST_SY_FLUSH = 4'd8;
    localparam t_pc ST_RTR_EV   = 4'd9;
    localparam t_pc ST_APP_LD   = 4'd10;
    localparam t_pc ST_APP_EV   = 4'd11;

    function automatic t_uword mk_uw(t_op op, logic inc, t_cond cond, t_pc tgt);
        t_uword w;
        w.op   = op;
        w.inc  = inc;
        w.cond = cond;
        w.tgt  = tgt;
        return w;
    endfunction

    // Microcode ROM
    function automatic t_uword urom(t_pc a);
        t_uword w;
        case (a)
            ST_IDLE:     w = mk_uw(OP_NOP,     1'b0, C_ALWAYS, ST_IDLE);
            ST_TK_LD:    w = mk_uw(OP_LD_TMR,  1'b0, C_NEVER,  ST_IDLE);
            ST_TK_EV:    w = mk_uw(OP_EV_TICK, 1'b1, C_MORE,   ST_TK_LD);
            ST_FLUSH:    w = mk_uw(OP_FLUSH,   1'b0, C_ALWAYS, ST_IDLE);
            ST_SY_CHK:   w = mk_uw(OP_NOP,     1'b0, C_ABORT,  ST_IDLE);
            ST_SY_GO:    w = mk_uw(OP_MOD_GO,  1'b0, C_NEVER,  ST_IDLE);
            ST_SY_WAIT:  w = mk_uw(OP_NOP,     1'b0, C_BUSY,   ST_SY_WAIT);
            ST_SY_EV:    w = mk_uw(OP_EV_SYNC, 1'b1, C_MORE,   ST_SY_GO);
            ST_SY_FLUSH: w = mk_uw(OP_FLUSH,   1'b0, C_ALWAYS, ST_IDLE);
            ST_RTR_EV:   w = mk_uw(OP_EV_RTR,  1'b0, C_ALWAYS, ST_FLUSH);
            ST_APP_LD:   w = mk_uw(OP_LD_INH,  1'b0, C_NEVER,  ST_IDLE);
            ST_APP_EV:   w = mk_uw(OP_EV_APP,  1'b0, C_ALWAYS, ST_FLUSH);
            default:     w = mk_uw(OP_NOP,     1'b0, C_ALWAYS, ST_IDLE);
        endcase
        return w;
    endfunction

    // Entry point of each event's program
    function automatic t_pc start_of(t_func f);
        t_pc a;
        case (f)
            FUNC_TICK: a = ST_TK_LD;
            FUNC_SYNC: a = ST_SY_CHK;
            FUNC_RTR:  a = ST_RTR_EV;
            FUNC_APP:  a = ST_APP_LD;
            default:   a = ST_IDLE;
        endcase
        return a;
    endfunction

endpackage

// File: hdl/pdotts_in_if.sv
`timescale 1ns / 1ps
// Event input channel of the PDO trigger scheduler: valid/ready plus payload.
// Depends on pdotts_pkg for the field types.
interface pdotts_in_if;
    import pdotts_pkg::*;

    logic  valid;
    logic  ready;
    t_func func;
    t_pdo  pdo_index;
    t_cnt8 sync_count;
    t_time event_time_us;
    t_time now_us;

    modport source (output valid, func, pdo_index, sync_count, event_time_us, now_us,
                    input ready);
    modport sink   (input valid, func, pdo_index, sync_count, event_time_us, now_us,
                    output ready);
endinterface

// File: hdl/pdotts_out_if.sv
`timescale 1ns / 1ps
// Send result channel of the PDO trigger scheduler: valid/ready plus payload.
// Depends on pdotts_pkg for the field types.
interface pdotts_out_if;
    import pdotts_pkg::*;

    logic  valid;
    logic  ready;
    t_pdo  send_pdo;
    t_time send_time_us;
    logic  last;

    modport source (output valid, send_pdo, send_time_us, last, input ready);
    modport sink   (input valid, send_pdo, send_time_us, last, output ready);
endinterface

// File: hdl/pdotts_mod.sv
`timescale 1ns / 1ps
// Bit-serial 8-bit remainder unit (restoring, one dividend bit per cycle).
// Depends on pdotts_pkg for t_cnt8.
module pdotts_mod (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  pdotts_pkg::t_cnt8 i_dividend,
    input  pdotts_pkg::t_cnt8 i_divisor,
    output logic             o_busy,
    output logic             o_zero
);
    import pdotts_pkg::*;

    logic       r_busy;
    logic [2:0] r_cnt;
    t_cnt8      r_rem;
    t_cnt8      r_dvd;
    t_cnt8      r_dsr;
    logic [8:0] sh;
    logic [8:0] diff;

    // Shift in the next dividend bit, subtract when it fits
    assign sh   = {r_rem, r_dvd[7]};
    assign diff = sh - {1'b0, r_dsr};

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 3'd1;
            if (r_cnt == 3'd7) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvd <= i_dividend;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[6:0], 1'b0};
            if (sh >= {1'b0, r_dsr}) begin
                r_rem <= diff[7:0];
            end else begin
                r_rem <= sh[7:0];
            end
        end
    end

    assign o_busy = r_busy;
    assign o_zero = (r_rem == '0);

endmodule

// File: hdl/pdotts_seq.sv
`timescale 1ns / 1ps
// Microcode sequencer: step counter, ROM fetch and conditional jumps.
// Depends on pdotts_pkg for the ROM, control word and flag types.
module pdotts_seq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  pdotts_pkg::t_func  i_func,
    input  logic               i_stall,
    input  pdotts_pkg::t_flags i_flags,
    output pdotts_pkg::t_uword o_uw,
    output logic               o_idle
);
    import pdotts_pkg::*;

    t_pc    r_pc;
    t_pc    n_pc;
    t_uword uw;
    logic   take;

    assign uw     = urom(r_pc);
    assign o_uw   = uw;
    assign o_idle = (r_pc == ST_IDLE);

    // Jump condition
    always_comb begin
        case (uw.cond)
            C_NEVER:  take = 1'b0;
            C_ALWAYS: take = 1'b1;
            C_MORE:   take = i_flags.more;
            C_BUSY:   take = i_flags.busy;
            C_ABORT:  take = i_flags.abort;
            default:  take = 1'b0;
        endcase
    end

    // Next step
    always_comb begin
        if (o_idle && i_start) begin
            n_pc = start_of(i_func);
        end else if (i_stall) begin
            n_pc = r_pc;
        end else if (take) begin
            n_pc = uw.tgt;
        end else begin
            n_pc = r_pc + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= ST_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

// File: hdl/pdo_transmit_trigger_scheduler_unit.sv
`timescale 1ns / 1ps
// Top level of the transmit PDO trigger scheduler: config registers, datapath.
// Depends on pdotts_pkg, pdotts_in_if, pdotts_out_if, pdotts_seq, pdotts_mod.
//
//   channel  dir  handshake      payload
//   i_in     in   valid/ready    func, pdo_index, sync_count, event_time_us, now_us
//   o_out    out  valid/ready    send_pdo, send_time_us, last
//   i_cfg_*  in   write enable   i_cfg_idx, i_cfg_data
//
// One event at a time; ready is high while the sequencer sits at its idle step.
// A tick loads each PDO's event timer and evaluates it. A sync checks the window (if
// late, back to idle), then per PDO runs the serial remainder and evaluates. Requests
// load inhibit (application only) and evaluate; all flush. Disabled nodes stay idle.
// Sends pass a one-entry hold register then an output register; evaluate and flush
// steps stall while the output register is full and not taken. Sync reset, active low.
`include "pdo_transmit_trigger_scheduler_unit_defines.svh"

module pdo_transmit_trigger_scheduler_unit #(
    parameter int NUM_PDO = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  pdotts_pkg::t_cfg_idx  i_cfg_idx,
    input  pdotts_pkg::t_cfg_data i_cfg_data,
    pdotts_in_if.sink             i_in,
    pdotts_out_if.source          o_out
);
    import pdotts_pkg::*;

    // Configuration registers
    logic        r_node_en;
    logic [31:0] r_tx_types;
    logic [63:0] r_evt_tmrs;
    logic [63:0] r_inh_times;
    logic [3:0]  r_pdo_en;
    logic [3:0]  r_tmr_sup;
    logic [3:0]  r_inh_sup;
    t_time       r_sync_win;

    // Per-PDO state
    t_time              r_last [NUM_PDO];
    logic [NUM_PDO-1:0] r_pend;

    // Transaction registers
    t_pdo  r_n;
    t_cnt8 r_cnt8;
    t_time r_evt;
    t_time r_now;
    t_time r_thr;

    // Hold and output registers
    logic  r_hold_v;
    t_pdo  r_hold_pdo;
    t_time r_hold_time;
    logic  r_out_valid;
    t_pdo  r_out_pdo;
    t_time r_out_time;
    logic  r_out_last;

    t_uword uw;
    t_flags flags;
    logic   idle;
    logic   accept;
    logic   stall;
    logic   slot_free;
    logic   needs_slot;
    logic   mod_busy;
    logic   mod_zero;
    logic   in_range;
    logic   pdo_on;
    logic [7:0]  ty;
    logic [15:0] tmr_sel;
    logic [15:0] inh_sel;
    t_time  sel_last;
    logic   sel_pend;
    logic   go;
    logic   set_pend;
    t_time  send_time;

    assign accept      = i_in.valid && i_in.ready;
    assign i_in.ready  = idle;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_en   <= 1'b0;
            r_tx_types  <= '0;
            r_evt_tmrs  <= '0;
            r_inh_times <= '0;
            r_pdo_en    <= '0;
            r_tmr_sup   <= 4'hF;
            r_inh_sup   <= 4'hF;
            r_sync_win  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_NODE_ENABLE: r_node_en   <= i_cfg_data[0];
                CFG_TX_TYPES:    r_tx_types  <= i_cfg_data[31:0];
                CFG_EVT_TIMERS:  r_evt_tmrs  <= i_cfg_data;
                CFG_INH_TIMES:   r_inh_times <= i_cfg_data;
                CFG_PDO_ENABLE:  r_pdo_en    <= i_cfg_data[3:0];
                CFG_TMR_SUP:     r_tmr_sup   <= i_cfg_data[3:0];
                CFG_INH_SUP:     r_inh_sup   <= i_cfg_data[3:0];
                CFG_SYNC_WIN:    r_sync_win  <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // Sequencer
    pdotts_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (accept && r_node_en),
        .i_func  (i_in.func),
        .i_stall (stall),
        .i_flags (flags),
        .o_uw    (uw),
        .o_idle  (idle)
    );

    // Per-PDO field selection at the scan index
    assign in_range = (int'(r_n) < NUM_PDO);
    assign pdo_on   = in_range && r_pdo_en[r_n];
    assign ty       = 8'(r_tx_types >> {r_n, 3'b000});
    assign tmr_sel  = 16'(r_evt_tmrs >> {r_n, 4'b0000});
    assign inh_sel  = 16'(r_inh_times >> {r_n, 4'b0000});

    always_comb begin
        sel_last = '0;
        sel_pend = 1'b0;
        for (int k = 0; k < NUM_PDO; k++) begin
            if (2'(k) == r_n) begin
                sel_last = r_last[k];
                sel_pend = r_pend[k];
            end
        end
    end

    // Cyclic sync remainder
    pdotts_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (uw.op == OP_MOD_GO),
        .i_dividend (r_cnt8),
        .i_divisor  (ty),
        .o_busy     (mod_busy),
        .o_zero     (mod_zero)
    );

    // Jump flags
    assign flags.more  = (r_n != 2'(NUM_PDO - 1));
    assign flags.busy  = mod_busy;
    assign flags.abort = (r_sync_win != '0) && ((r_now - r_evt) > r_sync_win);

    // Output slot and stall
    assign slot_free  = !r_out_valid || o_out.ready;
    assign needs_slot = (uw.op == OP_EV_TICK) || (uw.op == OP_EV_SYNC) ||
                        (uw.op == OP_EV_RTR) || (uw.op == OP_EV_APP) ||
                        (uw.op == OP_FLUSH);
    assign stall      = needs_slot && !slot_free;

    // Send decision per operation
    always_comb begin
        go        = 1'b0;
        set_pend  = 1'b0;
        send_time = r_evt;
        case (uw.op)
            OP_EV_TICK: begin
                go = pdo_on && (ty >= TYPE_EVENT_A) && r_tmr_sup[r_n] &&
                     (r_thr != '0) && ((r_evt - sel_last) >= r_thr);
            end
            OP_EV_SYNC: begin
                go = pdo_on &&
                     (((ty == TYPE_ACYCLIC) && sel_pend) ||
                      ((ty != TYPE_ACYCLIC) && (ty <= TYPE_SYNC_MAX) &&
                       (r_cnt8 != '0) && mod_zero) ||
                      ((ty == TYPE_RTR_SYNC) && sel_pend));
            end
            OP_EV_RTR: begin
                set_pend = pdo_on && (ty == TYPE_RTR_SYNC);
                go       = pdo_on && (ty == TYPE_RTR_EVENT);
            end
            OP_EV_APP: begin
                send_time = r_now;
                set_pend  = pdo_on && (ty == TYPE_ACYCLIC);
                go        = pdo_on && (ty >= TYPE_EVENT_A) &&
                            (!r_inh_sup[r_n] || (r_thr == '0) ||
                             ((r_now - sel_last) >= r_thr));
            end
            default: ;
        endcase
    end

    // Transaction capture, scan index and timer threshold
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_n    <= ((i_in.func == FUNC_RTR) || (i_in.func == FUNC_APP)) ?
                      i_in.pdo_index : '0;
            r_cnt8 <= i_in.sync_count;
            r_evt  <= i_in.event_time_us;
            r_now  <= i_in.now_us;
        end else if (!stall && uw.inc) begin
            r_n <= r_n + 2'd1;
        end
        case (uw.op)
            OP_LD_TMR: r_thr <= 32'(tmr_sel) * MS_TO_US;
            OP_LD_INH: r_thr <= 32'(inh_sel) * INHIBIT_UNIT_US;
            default: ;
        endcase
    end

    // Last send times and pending flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_PDO; k++) begin
                r_last[k] <= '0;
            end
            r_pend <= '0;
        end else if (!stall) begin
            for (int k = 0; k < NUM_PDO; k++) begin
                if (2'(k) == r_n) begin
                    if (go) begin
                        r_last[k] <= send_time;
                        r_pend[k] <= 1'b0;
                    end else if (set_pend) begin
                        r_pend[k] <= 1'b1;
                    end
                end
            end
        end
    end

    // Hold one send back so the final one can be marked
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_v    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!stall && (go || (uw.op == OP_FLUSH)) && r_hold_v) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (!stall && go) begin
                r_hold_v <= 1'b1;
            end else if (!stall && (uw.op == OP_FLUSH)) begin
                r_hold_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!stall && go) begin
            r_hold_pdo  <= r_n;
            r_hold_time <= send_time;
            if (r_hold_v) begin
                r_out_pdo  <= r_hold_pdo;
                r_out_time <= r_hold_time;
                r_out_last <= 1'b0;
            end
        end else if (!stall && (uw.op == OP_FLUSH) && r_hold_v) begin
            r_out_pdo  <= r_hold_pdo;
            r_out_time <= r_hold_time;
            r_out_last <= 1'b1;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.send_pdo     = r_out_pdo;
    assign o_out.send_time_us = r_out_time;
    assign o_out.last         = r_out_last;

    // Checks
    `PDOTTS_ASSERT_NOW(a_idle_hold_empty, idle, !r_hold_v, "send left in hold at idle")
    `PDOTTS_ASSERT_NOW(a_idle_mod_quiet, idle, !mod_busy, "remainder unit busy at idle")
    `PDOTTS_ASSERT_NOW(a_mid_send_has_next, r_out_valid && !r_out_last, r_hold_v,
                       "non-final send without a following send")
    `PDOTTS_ASSERT_NEXT(a_mod_starts, uw.op == OP_MOD_GO, mod_busy,
                        "remainder unit did not start")

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for pdo_transmit_trigger_scheduler_unit: a queue-fed event driver,
// a send monitor, and a transmission-type predictor. Needs pdotts_pkg and the channel ifs.
module testbench;
    import pdotts_pkg::*;

    localparam int NUM_PDO         = 4;
    localparam int RAND_PHASES     = 9;
    localparam int ITEMS_PER_PHASE = 40;
    localparam int SETTLE_CYCLES   = 64;
    localparam int HOLD_CYCLES     = 400;
    localparam int LIMIT_NS        = 1_000_000;
    localparam logic [7:0] TYPE_EVENT_B    = 8'd255;
    localparam logic [7:0] TYPE_UNUSED_MIN = 8'd241;
    localparam logic [7:0] TYPE_UNUSED_MAX = 8'd251;

    typedef struct packed {
        t_func func;
        t_pdo  idx;
        t_cnt8 cnt;
        t_time evt;
        t_time now;
    } t_pdo_event;

    typedef struct packed {
        t_pdo  pdo;
        t_time stamp;
        logic  last;
    } t_pdo_send;

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      cfg_we;
    t_cfg_idx  cfg_idx;
    t_cfg_data cfg_data;

    pdotts_in_if  ev_ch ();
    pdotts_out_if send_ch ();

    pdo_transmit_trigger_scheduler_unit #(.NUM_PDO(NUM_PDO)) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (ev_ch),
        .o_out      (send_ch)
    );

    // Shadow copy of the scheduler configuration and state
    logic        cfg_node_en  = 1'b0;
    logic [31:0] cfg_types    = '0;
    logic [63:0] cfg_timers   = '0;
    logic [63:0] cfg_inhibits = '0;
    logic [3:0]  cfg_pdo_en   = '0;
    logic [3:0]  cfg_tmr_sup  = 4'hF;
    logic [3:0]  cfg_inh_sup  = 4'hF;
    t_time       cfg_sync_win = '0;
    t_time       last_sent [NUM_PDO] = '{default: '0};
    logic        pending   [NUM_PDO] = '{default: 1'b0};

    t_pdo_event event_q [$];
    t_pdo_send  sends_due [$];
    int         mismatches = 0;
    t_time      sim_us = '0;

    bit         sender_gaps_on     = 1'b1;
    bit         receiver_stalls_on = 1'b1;
    bit         hold_req           = 1'b0;
    bit         offering           = 1'b0;
    t_pdo_event cur_ev;
    int         gap_left   = 0;
    int         stall_left = 0;
    int         hold_left  = 0;
    logic       send_ready_next;
    t_pdo_send  got;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Record one send in the shadow state and queue it as expected
    function automatic void log_send(t_pdo p, t_time t);
        t_pdo_send s;
        last_sent[p] = t;
        pending[p]   = 1'b0;
        s.pdo   = p;
        s.stamp = t;
        s.last  = 1'b0;
        sends_due.push_back(s);
    endfunction

    // Work out the sends one event causes, in ascending PDO order
    function automatic void predict_sends(t_pdo_event ev);
        int          n;
        int          base;
        logic [7:0]  ty;
        t_time       span;
        logic        fire;
        base = sends_due.size();
        if (!cfg_node_en) return;
        case (ev.func)
            FUNC_TICK: begin
                for (n = 0; n < NUM_PDO; n++) begin
                    ty   = cfg_types[8*n +: 8];
                    span = t_time'(cfg_timers[16*n +: 16]) * MS_TO_US;
                    if (cfg_pdo_en[n] && ty >= TYPE_EVENT_A && cfg_tmr_sup[n] && span != 0 &&
                        t_time'(ev.evt - last_sent[n]) >= span)
                        log_send(t_pdo'(n), ev.evt);
                end
            end
            FUNC_SYNC: begin
                for (n = 0; n < NUM_PDO; n++) begin
                    ty   = cfg_types[8*n +: 8];
                    fire = (ty == TYPE_ACYCLIC && pending[n]) ||
                           (ty != TYPE_ACYCLIC && ty <= TYPE_SYNC_MAX && ev.cnt != 0 &&
                            (ev.cnt % ty) == 0) ||
                           (ty == TYPE_RTR_SYNC && pending[n]);
                    if (cfg_pdo_en[n] && fire) begin
                        // sync window closed: the rest of the scan is dropped
                        if (cfg_sync_win != 0 && t_time'(ev.now - ev.evt) > cfg_sync_win)
                            break;
                        log_send(t_pdo'(n), ev.evt);
                    end
                end
            end
            FUNC_RTR: begin
                ty = cfg_types[8*ev.idx +: 8];
                if (cfg_pdo_en[ev.idx]) begin
                    if (ty == TYPE_RTR_SYNC) pending[ev.idx] = 1'b1;
                    else if (ty == TYPE_RTR_EVENT) log_send(ev.idx, ev.evt);
                end
            end
            default: begin
                ty   = cfg_types[8*ev.idx +: 8];
                span = t_time'(cfg_inhibits[16*ev.idx +: 16]) * INHIBIT_UNIT_US;
                if (cfg_pdo_en[ev.idx]) begin
                    if (ty == TYPE_ACYCLIC) begin
                        pending[ev.idx] = 1'b1;
                    end else if (ty >= TYPE_EVENT_A) begin
                        if (!cfg_inh_sup[ev.idx] || span == 0 ||
                            t_time'(ev.now - last_sent[ev.idx]) >= span)
                            log_send(ev.idx, ev.now);
                    end
                end
            end
        endcase
        if (sends_due.size() > base) sends_due[$].last = 1'b1;
    endfunction

    function automatic void note_mismatch(string what, t_pdo_send want, t_pdo_send seen);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s: expected pdo %0d time %08h last %0b, got pdo %0d time %08h last %0b",
                     $time, what, want.pdo, want.stamp, want.last,
                     seen.pdo, seen.stamp, seen.last);
    endfunction

    // Event driver: one transaction in flight, random gap after each acceptance
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            ev_ch.valid <= 1'b0;
            offering = 1'b0;
            gap_left = 0;
        end else begin
            if (ev_ch.valid && ev_ch.ready) begin
                predict_sends(cur_ev);
                offering = 1'b0;
                gap_left = sender_gaps_on ? $urandom_range(0, 12) : 0;
            end
            if (!offering) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (event_q.size() > 0) begin
                    cur_ev   = event_q.pop_front();
                    offering = 1'b1;
                    ev_ch.func          <= cur_ev.func;
                    ev_ch.pdo_index     <= cur_ev.idx;
                    ev_ch.sync_count    <= cur_ev.cnt;
                    ev_ch.event_time_us <= cur_ev.evt;
                    ev_ch.now_us        <= cur_ev.now;
                end
            end
            ev_ch.valid <= offering;
        end
    end

    // Send monitor: compare against the oldest expectation, then pick ready
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            send_ch.ready <= 1'b0;
            stall_left = 0;
            hold_left  = 0;
        end else begin
            if (send_ch.valid && send_ch.ready) begin
                got.pdo   = send_ch.send_pdo;
                got.stamp = send_ch.send_time_us;
                got.last  = send_ch.last;
                if (sends_due.size() == 0) begin
                    note_mismatch("unexpected send", '0, got);
                end else if (got.pdo !== sends_due[0].pdo ||
                             got.stamp !== sends_due[0].stamp ||
                             got.last !== sends_due[0].last) begin
                    note_mismatch("send mismatch", sends_due.pop_front(), got);
                end else begin
                    void'(sends_due.pop_front());
                end
                stall_left = receiver_stalls_on ? $urandom_range(0, 12) : 0;
            end
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                send_ready_next = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                send_ready_next = 1'b0;
            end else begin
                send_ready_next = 1'b1;
            end
            send_ch.ready <= send_ready_next;
        end
    end

    task automatic write_reg(t_cfg_idx idx, t_cfg_data val);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        case (idx)
            CFG_NODE_ENABLE: cfg_node_en  = val[0];
            CFG_TX_TYPES:    cfg_types    = val[31:0];
            CFG_EVT_TIMERS:  cfg_timers   = val;
            CFG_INH_TIMES:   cfg_inhibits = val;
            CFG_PDO_ENABLE:  cfg_pdo_en   = val[3:0];
            CFG_TMR_SUP:     cfg_tmr_sup  = val[3:0];
            CFG_INH_SUP:     cfg_inh_sup  = val[3:0];
            default:         cfg_sync_win = val[31:0];
        endcase
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic load_setup(logic node, logic [31:0] types, logic [63:0] tmrs,
                              logic [63:0] inhs, logic [3:0] pdo_en, logic [3:0] tmr_sup,
                              logic [3:0] inh_sup, t_time win);
        write_reg(CFG_NODE_ENABLE, t_cfg_data'(node));
        write_reg(CFG_TX_TYPES,    t_cfg_data'(types));
        write_reg(CFG_EVT_TIMERS,  tmrs);
        write_reg(CFG_INH_TIMES,   inhs);
        write_reg(CFG_PDO_ENABLE,  t_cfg_data'(pdo_en));
        write_reg(CFG_TMR_SUP,     t_cfg_data'(tmr_sup));
        write_reg(CFG_INH_SUP,     t_cfg_data'(inh_sup));
        write_reg(CFG_SYNC_WIN,    t_cfg_data'(win));
    endtask

    function automatic logic [7:0] pick_type();
        case ($urandom_range(0, 9))
            0:       return TYPE_ACYCLIC;
            1:       return 8'($urandom_range(1, 6));
            2:       return 8'($urandom_range(1, TYPE_SYNC_MAX));
            3:       return 8'($urandom_range(TYPE_UNUSED_MIN, TYPE_UNUSED_MAX));
            4:       return TYPE_RTR_SYNC;
            5:       return TYPE_RTR_EVENT;
            6, 7:    return TYPE_EVENT_A;
            default: return TYPE_EVENT_B;
        endcase
    endfunction

    // Zero, all ones, or a short period that the event spacing can reach
    function automatic logic [15:0] pick_period(int unsigned top);
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom_range(1, top));
        endcase
    endfunction

    task automatic load_random_setup(logic node);
        int          n;
        logic [31:0] types;
        logic [63:0] tmrs;
        logic [63:0] inhs;
        t_time       win;
        for (n = 0; n < NUM_PDO; n++) begin
            types[8*n +: 8]  = pick_type();
            tmrs[16*n +: 16] = pick_period(5);
            inhs[16*n +: 16] = pick_period(30);
        end
        case ($urandom_range(0, 5))
            0, 1:    win = '0;
            2:       win = '1;
            default: win = t_time'($urandom_range(20, 120));
        endcase
        load_setup(node, types, tmrs, inhs,
                   ($urandom_range(0, 2) == 0) ? 4'($urandom) : 4'hF,
                   4'($urandom), 4'($urandom), win);
    endtask

    task automatic push_event(t_func func, t_pdo idx, t_cnt8 cnt, t_time evt, t_time now);
        t_pdo_event ev;
        ev.func = func;
        ev.idx  = idx;
        ev.cnt  = cnt;
        ev.evt  = evt;
        ev.now  = now;
        event_q.push_back(ev);
    endtask

    // Events on a running microsecond clock, with occasional fully random times
    function automatic t_pdo_event next_event();
        t_pdo_event ev;
        sim_us  += $urandom_range(0, 2500);
        case ($urandom_range(0, 9))
            0, 1, 2: ev.func = FUNC_TICK;
            3, 4, 5: ev.func = FUNC_SYNC;
            6, 7:    ev.func = FUNC_RTR;
            default: ev.func = FUNC_APP;
        endcase
        ev.idx = t_pdo'($urandom_range(0, NUM_PDO - 1));
        ev.cnt = ($urandom_range(0, 9) < 6) ? t_cnt8'($urandom_range(0, 12))
                                            : t_cnt8'($urandom_range(0, 240));
        if ($urandom_range(0, 19) == 0) begin
            ev.evt = $urandom;
            ev.now = $urandom;
        end else begin
            ev.evt = sim_us;
            ev.now = sim_us + $urandom_range(0, 120);
        end
        return ev;
    endfunction

    // Wait until every event is taken and every send has come back
    task automatic settle();
        while (event_q.size() != 0 || offering || sends_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        int ph;
        int count;
        i_rst_n             = 1'b0;
        cfg_we              = 1'b0;
        cfg_idx             = CFG_NODE_ENABLE;
        cfg_data            = '0;
        ev_ch.valid         = 1'b0;
        ev_ch.func          = FUNC_TICK;
        ev_ch.pdo_index     = '0;
        ev_ch.sync_count    = '0;
        ev_ch.event_time_us = '0;
        ev_ch.now_us        = '0;
        send_ch.ready       = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Node disabled after reset: nothing may be sent
        push_event(FUNC_TICK, 2'd0, 8'd0, 32'hFFFF_FFFF, 32'd0);
        push_event(FUNC_SYNC, 2'd1, 8'd1, 32'd10, 32'd10);
        push_event(FUNC_RTR,  2'd2, 8'd0, 32'd20, 32'd20);
        push_event(FUNC_APP,  2'd3, 8'd0, 32'd30, 32'd30);
        settle();

        // Acyclic, cyclic, remote-sync and event PDOs side by side
        load_setup(1'b1, {TYPE_EVENT_A, TYPE_RTR_SYNC, 8'd3, TYPE_ACYCLIC},
                   64'h0001_0000_0000_0000, 64'h000A_0000_0000_0000,
                   4'hF, 4'hF, 4'hF, '0);
        push_event(FUNC_APP,  2'd0, 8'd0,   32'd50,  32'd50);
        push_event(FUNC_SYNC, 2'd0, 8'd0,   32'd100, 32'd100);
        push_event(FUNC_RTR,  2'd2, 8'd0,   32'd200, 32'd200);
        push_event(FUNC_SYNC, 2'd3, 8'd3,   32'd300, 32'd300);
        push_event(FUNC_SYNC, 2'd1, 8'd240, 32'd400, 32'd400);
        // event timer one microsecond short, exact, then across the wrap
        push_event(FUNC_TICK, 2'd0, 8'd0, 32'd999,        32'd999);
        push_event(FUNC_TICK, 2'd0, 8'd0, 32'd1000,       32'd1000);
        push_event(FUNC_TICK, 2'd0, 8'd0, 32'hFFFF_FFFF,  32'hFFFF_FFFF);
        // inhibit time one microsecond short, then exact
        push_event(FUNC_APP,  2'd3, 8'd0, 32'd0, 32'd998);
        push_event(FUNC_APP,  2'd3, 8'd0, 32'd0, 32'd999);
        // requests to types that ignore them
        push_event(FUNC_RTR,  2'd3, 8'd0, 32'd5, 32'd5);
        push_event(FUNC_APP,  2'd1, 8'd0, 32'd6, 32'd6);
        push_event(FUNC_RTR,  2'd0, 8'd0, 32'd7, 32'd7);
        settle();

        // Remote event, unsupported timer and inhibit, sync window, disabled PDO
        load_setup(1'b1, {8'd2, 8'd1, TYPE_EVENT_B, TYPE_RTR_EVENT},
                   64'h0000_0000_FFFF_0000, 64'h0000_0000_FFFF_0000,
                   4'b0111, 4'b1101, 4'b1101, 32'd50);
        push_event(FUNC_RTR,  2'd0, 8'd0, 32'd5000,      32'd5000);
        push_event(FUNC_TICK, 2'd0, 8'd0, 32'h8000_0000, 32'h8000_0000);
        push_event(FUNC_APP,  2'd1, 8'd0, 32'd8,         32'd10);
        push_event(FUNC_SYNC, 2'd0, 8'd2, 32'd6000,      32'd6060);
        push_event(FUNC_SYNC, 2'd0, 8'd2, 32'd6000,      32'd6050);
        push_event(FUNC_SYNC, 2'd0, 8'd1, 32'd7000,      32'd6999);
        push_event(FUNC_RTR,  2'd3, 8'd0, 32'd7100,      32'd7100);
        push_event(FUNC_APP,  2'd2, 8'd0, 32'd7200,      32'd7200);
        settle();

        // Random phases; some without idling, one with a long receiver hold-off
        for (ph = 0; ph < RAND_PHASES; ph++) begin
            sender_gaps_on     = (ph != 2) && (ph != 3);
            receiver_stalls_on = (ph != 2) && (ph != 4);
            count = ITEMS_PER_PHASE;
            case (ph)
                0: load_setup(1'b1, '0, '0, '0, 4'hF, 4'h0, 4'h0, '1);
                1: load_setup(1'b1, '1, '1, '1, 4'hF, 4'hF, 4'hF, '0);
                5: begin
                    load_random_setup(1'b0);
                    count = 12;
                end
                default: load_random_setup(1'b1);
            endcase
            sim_us = ($urandom_range(0, 3) == 0) ? 32'hFFFF_8000 : $urandom;
            if (ph == 3) hold_req = 1'b1;
            repeat (count) event_q.push_back(next_event());
            settle();
        end

        mismatches += sends_due.size();
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Run limit
    initial begin
        #(LIMIT_NS);
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: pdo_transmit_trigger_scheduler_unit.f
+incdir+hdl
hdl/pdotts_pkg.sv
hdl/pdotts_in_if.sv
hdl/pdotts_out_if.sv
hdl/pdotts_mod.sv
hdl/pdotts_seq.sv
hdl/pdo_transmit_trigger_scheduler_unit.sv
test/testbench.sv
